@@ hdl/kws_pkg.sv @@
// shared types and constants for the wind spectrum evaluator
`timescale 1ns / 1ps
package kws_pkg;

    // base-2 logarithm, signed q.16
    typedef logic signed [31:0] log_t;

    localparam logic [14:0] LOG_C = 15'd22500;
    localparam int          ONE_Q16 = 65536;

    // x/6 as (x * DIV6_MUL) >> DIV6_SHIFT, exact for x below 2^29
    localparam logic [27:0] DIV6_MUL   = 28'd178956971;
    localparam int          DIV6_SHIFT = 30;

    // a reduced term this large skips the log(1 + x) step
    localparam log_t LS_BIG = 32'sd2097152;

    localparam logic [1:0] OP_ALONG  = 2'd0;
    localparam logic [1:0] OP_ACROSS = 2'd1;
    localparam logic [1:0] OP_VERT   = 2'd2;
    // spare code, treated as a cross component
    localparam logic [1:0] OP_SPARE  = 2'd3;

    localparam logic [1:0] REG_GAIN  = 2'd0;
    localparam logic [1:0] REG_SHAPE = 2'd1;
    localparam logic [1:0] REG_RISE  = 2'd2;
    // unused index, writes are dropped
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam logic [23:0] GAIN_RST  = 24'd16384;
    localparam logic [23:0] SHAPE_RST = 24'd1159168;
    localparam logic [23:0] RISE_RST  = 24'd3092480;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZSPD = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // per-beat flags that ride along the pipeline
    typedef struct packed {
        logic along;
        logic spd_zero;
        logic res_zero;
        logic sh_skip;
        logic ri_skip;
    } side_t;

endpackage

@@ hdl/karman_wind_spectrum_eval.sv @@
// top level of the von karman turbulence spectrum evaluator
`timescale 1ns / 1ps
// von karman spectrum evaluator: each input beat (component opcode, frequency,
// mean speed, length scale, sigma) gives one result beat with the power
// spectral density in q20.12 and a status code (ok, zero mean speed, saturated).
// the whole expression is worked in the base-2 log domain: seven log units
// take the operands, the reduced-frequency terms go through an exponential and
// a second log for log(1 + x), and a final exponential returns the density.
// the pipeline takes a new beat every cycle while the result side does not
// stall; a stall there freezes every stage at once, so nothing is lost or
// repeated. the user writes gain, shape and rise through the cfg port only
// while no beat is in flight; the block does not enforce this. cfg_ready is
// always high and an index beyond rise is ignored.
module karman_wind_spectrum_eval import kws_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    // input beats
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [23:0] s_frequency,
    input  logic [15:0] s_mean_speed,
    input  logic [15:0] s_length_scale,
    input  logic [15:0] s_sigma,
    // result beats
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_psd,
    output logic [1:0]  m_status
);
    localparam int SD = 18;   // side flag stages
    localparam int MD = 7;    // reduced term carry

    typedef struct packed {
        log_t ls_sh;
        log_t ls_ri;
        log_t base;
    } mid_t;

    logic [23:0] gain_reg, shape_reg, rise_reg;

    logic        en;
    logic [SD-1:0] vld_reg;
    side_t       sd_reg [SD];
    side_t       side_c;
    mid_t        mid_reg [MD];

    // log unit outputs
    log_t lg_len, lg_spd, lg_frq, lg_shp, lg_rse, lg_gn, lg_sg;

    // stage 5 and 6
    log_t lt5_reg, lgf5_reg, lgsh5_reg, lgri5_reg, bpre5_reg;
    log_t lssh6_reg, lsri6_reg, base6_reg;

    // reduced term exponentials, valid at stage 8
    logic [16:0]        mant_sh, mant_ri;
    logic signed [15:0] ex_sh, ex_ri;

    // one plus the reduced term, stage 9
    logic [48:0] ssh9_reg, sri9_reg;
    log_t        lp_sh, lp_ri;

    // stage 14 to 16
    logic [23:0] ld14_reg;
    log_t        lr14_reg, base14_reg;
    logic [55:0] q15_reg;
    log_t        lr15_reg, base15_reg;
    log_t        l16_reg;

    // final exponential, valid at stage 18
    logic [16:0]        mant_o;
    logic signed [15:0] ex_o;

    logic        m_valid_reg;
    logic [31:0] m_psd_reg;
    logic [1:0]  m_status_reg;

    // the whole pipe moves while the result register is free or being taken
    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= GAIN_RST;
            shape_reg <= SHAPE_RST;
            rise_reg  <= RISE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GAIN:  gain_reg  <= cfg_data;
                REG_SHAPE: shape_reg <= cfg_data;
                REG_RISE:  rise_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // special cases are settled at the door and ride along
    always_comb begin
        side_c.along    = (s_opcode == OP_ALONG);
        side_c.spd_zero = (s_mean_speed == 16'd0);
        side_c.res_zero = (gain_reg == 24'd0) || (s_sigma == 16'd0) ||
                          (s_length_scale == 16'd0);
        side_c.sh_skip  = (shape_reg == 24'd0) || (s_frequency == 24'd0);
        side_c.ri_skip  = (rise_reg == 24'd0) || (s_frequency == 24'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SD-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0] <= side_c;
            for (int k = 1; k < SD; k++) begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    // operand logs
    kws_log2 #(.W(16), .FRAC(4))  u_lg_len (.aclk(aclk), .en(en), .x(s_length_scale),
                                            .lg(lg_len));
    kws_log2 #(.W(16), .FRAC(8))  u_lg_spd (.aclk(aclk), .en(en), .x(s_mean_speed),
                                            .lg(lg_spd));
    kws_log2 #(.W(24), .FRAC(16)) u_lg_frq (.aclk(aclk), .en(en), .x(s_frequency),
                                            .lg(lg_frq));
    kws_log2 #(.W(24), .FRAC(12)) u_lg_shp (.aclk(aclk), .en(en), .x(shape_reg),
                                            .lg(lg_shp));
    kws_log2 #(.W(24), .FRAC(12)) u_lg_rse (.aclk(aclk), .en(en), .x(rise_reg),
                                            .lg(lg_rse));
    kws_log2 #(.W(24), .FRAC(12)) u_lg_gn  (.aclk(aclk), .en(en), .x(gain_reg),
                                            .lg(lg_gn));
    kws_log2 #(.W(16), .FRAC(10)) u_lg_sg  (.aclk(aclk), .en(en), .x(s_sigma),
                                            .lg(lg_sg));

    // log of the time scale, then the reduced terms and the common base
    always_ff @(posedge aclk) begin
        if (en) begin
            lt5_reg   <= lg_len - lg_spd;
            lgf5_reg  <= lg_frq;
            lgsh5_reg <= lg_shp;
            lgri5_reg <= lg_rse;
            bpre5_reg <= lg_gn + (lg_sg <<< 1);
            lssh6_reg <= lgsh5_reg + ((lgf5_reg + lt5_reg) <<< 1);
            lsri6_reg <= lgri5_reg + ((lgf5_reg + lt5_reg) <<< 1);
            base6_reg <= bpre5_reg + lt5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mid_reg[0] <= '{ls_sh: lssh6_reg, ls_ri: lsri6_reg, base: base6_reg};
            for (int k = 1; k < MD; k++) begin
                mid_reg[k] <= mid_reg[k-1];
            end
        end
    end

    kws_exp2 u_ex_sh (.aclk(aclk), .en(en), .l(lssh6_reg), .mant(mant_sh), .ex(ex_sh));
    kws_exp2 u_ex_ri (.aclk(aclk), .en(en), .l(lsri6_reg), .mant(mant_ri), .ex(ex_ri));

    // scale the mantissa into q16 and add one; large terms bypass this later
    function automatic logic [48:0] one_plus(input logic [16:0] mant,
                                             input logic signed [15:0] ex);
        logic [15:0] neg;
        logic [47:0] v;
        begin
            neg = 16'd0 - ex;
            v   = 48'd0;
            if (!ex[15]) begin
                v = {31'b0, mant} << ex[4:0];
            end else if (neg < 16'd17) begin
                v = {31'b0, mant >> neg[4:0]};
            end
            one_plus = {1'b0, v} + 49'd65536;
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            ssh9_reg <= one_plus(mant_sh, ex_sh);
            sri9_reg <= one_plus(mant_ri, ex_ri);
        end
    end

    kws_log2 #(.W(49), .FRAC(16)) u_lp_sh (.aclk(aclk), .en(en), .x(ssh9_reg), .lg(lp_sh));
    kws_log2 #(.W(49), .FRAC(16)) u_lp_ri (.aclk(aclk), .en(en), .x(sri9_reg), .lg(lp_ri));

    // pick the log(1 + x) terms, divide the denominator power by six, combine
    always_ff @(posedge aclk) begin
        logic [27:0] num;
        if (en) begin
            if (sd_reg[12].sh_skip) begin
                ld14_reg <= 24'd0;
            end else if (mid_reg[MD-1].ls_sh >= LS_BIG) begin
                ld14_reg <= mid_reg[MD-1].ls_sh[23:0];
            end else begin
                ld14_reg <= lp_sh[23:0];
            end
            if (sd_reg[12].ri_skip) begin
                lr14_reg <= '0;
            end else if (mid_reg[MD-1].ls_ri >= LS_BIG) begin
                lr14_reg <= mid_reg[MD-1].ls_ri;
            end else begin
                lr14_reg <= lp_ri;
            end
            base14_reg <= mid_reg[MD-1].base;

            num = sd_reg[13].along ? ({4'b0, ld14_reg} + {2'b0, ld14_reg, 2'b0})
                                   : ({4'b0, ld14_reg} + {3'b0, ld14_reg, 1'b0} +
                                      {1'b0, ld14_reg, 3'b0});
            q15_reg    <= {28'b0, num} * {28'b0, DIV6_MUL};
            lr15_reg   <= sd_reg[13].along ? log_t'(0) : lr14_reg;
            base15_reg <= base14_reg;

            l16_reg <= base15_reg - log_t'(q15_reg[55:DIV6_SHIFT]) + lr15_reg;
        end
    end

    kws_exp2 u_ex_o (.aclk(aclk), .en(en), .l(l16_reg), .mant(mant_o), .ex(ex_o));

    // result register: q12 scaling, saturation and special cases
    always_ff @(posedge aclk) begin
        logic signed [16:0] sh;
        logic [16:0]        nsh;
        logic [56:0]        wide;
        logic [31:0]        psd;
        logic               sat;
        sh   = {ex_o[15], ex_o} - 17'sd4;
        nsh  = 17'd0 - sh;
        wide = {40'b0, mant_o} << sh[5:0];
        sat  = 1'b0;
        psd  = 32'd0;
        if (!sh[16]) begin
            if (sh > 17'sd40 || wide[56:32] != 25'd0) begin
                sat = 1'b1;
            end else begin
                psd = wide[31:0];
            end
        end else if (nsh < 17'd17) begin
            psd = {15'b0, mant_o >> nsh[4:0]};
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[SD-1];
        end
        if (en) begin
            if (sd_reg[SD-1].spd_zero) begin
                m_psd_reg    <= 32'd0;
                m_status_reg <= ST_ZSPD;
            end else if (sd_reg[SD-1].res_zero) begin
                m_psd_reg    <= 32'd0;
                m_status_reg <= ST_OK;
            end else if (sat) begin
                m_psd_reg    <= 32'hFFFF_FFFF;
                m_status_reg <= ST_SAT;
            end else begin
                m_psd_reg    <= psd;
                m_status_reg <= ST_OK;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_psd    = m_psd_reg;
    assign m_status = m_status_reg;
endmodule

@@ hdl/kws_log2.sv @@
// four-stage base-2 logarithm with quadratic mantissa correction
`timescale 1ns / 1ps
module kws_log2 import kws_pkg::*; #(
    parameter int W    = 24,
    parameter int FRAC = 0
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] x,
    output log_t         lg
);
    localparam int PW = $clog2(W);

    logic [W-1:0]    x1_reg;
    logic [PW-1:0]   p1_reg, p2_reg, p3_reg;
    logic [15:0]     m2_reg, m3_reg;
    logic [30:0]     prod3_reg;
    log_t            lg_reg;

    logic [PW-1:0]   p_c;
    logic [PW-1:0]   sh_c;
    logic [W+15:0]   norm_c;
    logic [32:0]     pf_c;
    logic [45:0]     cf_c;
    log_t            ptop_c;

    // leading one
    always_comb begin
        p_c = '0;
        for (int b = 0; b < W; b++) begin
            if (x[b]) begin
                p_c = PW'(b);
            end
        end
    end

    assign sh_c   = PW'(W - 1) - p1_reg;
    assign norm_c = {x1_reg, 16'b0} << sh_c;
    assign pf_c   = {17'b0, m2_reg} * (33'd65536 - {17'b0, m2_reg});
    assign cf_c   = {15'b0, prod3_reg} * {31'b0, LOG_C};
    assign ptop_c = log_t'(p3_reg) - log_t'(FRAC);

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg    <= x;
            p1_reg    <= p_c;
            m2_reg    <= norm_c[W+14 -: 16];
            p2_reg    <= p1_reg;
            prod3_reg <= pf_c[30:0];
            m3_reg    <= m2_reg;
            p3_reg    <= p2_reg;
            lg_reg    <= (ptop_c <<< 16) + log_t'(m3_reg) + log_t'(cf_c[45:32]);
        end
    end

    assign lg = lg_reg;
endmodule

@@ hdl/kws_exp2.sv @@
// two-stage base-2 exponential, q16 mantissa and integer exponent
`timescale 1ns / 1ps
module kws_exp2 import kws_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  log_t               l,
    output logic [16:0]        mant,
    output logic signed [15:0] ex
);
    logic [15:0]        g1_reg;
    logic signed [15:0] i1_reg, i2_reg;
    logic [30:0]        prod1_reg;
    logic [16:0]        mant2_reg;
    logic [32:0]        pf_c;
    logic [45:0]        cf_c;

    assign pf_c = {17'b0, l[15:0]} * (33'd65536 - {17'b0, l[15:0]});
    assign cf_c = {15'b0, prod1_reg} * {31'b0, LOG_C};

    always_ff @(posedge aclk) begin
        if (en) begin
            g1_reg    <= l[15:0];
            i1_reg    <= l[31:16];
            prod1_reg <= pf_c[30:0];
            mant2_reg <= 17'd65536 + {1'b0, g1_reg} - {3'b0, cf_c[45:32]};
            i2_reg    <= i1_reg;
        end
    end

    assign mant = mant2_reg;
    assign ex   = i2_reg;
endmodule

@@ tb/kws_spectrum_checker.sv @@
// checker for the wind spectrum evaluator: predicts each result beat and compares
`timescale 1ns / 1ps
module kws_spectrum_checker import kws_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [23:0] s_frequency,
    input  logic [15:0] s_mean_speed,
    input  logic [15:0] s_length_scale,
    input  logic [15:0] s_sigma,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_psd,
    input  logic [1:0]  m_status,
    output int          n_fail,
    output int          n_waiting
);

    typedef struct packed {
        logic [31:0] psd;
        logic [1:0]  status;
    } density_t;

    density_t    density_q[$];
    logic [23:0] gain_r, shape_r, rise_r;

    function automatic longint lg2_q16(longint unsigned x, int frac);
        int p;
        longint unsigned m;
        p = 63;
        while (p > 0 && x[p] == 1'b0) p--;
        if (p >= 16) m = (x >> (p - 16)) & 64'hFFFF;
        else         m = (x << (16 - p)) & 64'hFFFF;
        m = m + ((m * (64'd65536 - m) * 64'd22500) >> 32);
        return (longint'(p) - frac) * 65536 + longint'(m);
    endfunction

    // 2^(l/65536) in q.ofrac, flags a shift beyond 40
    function automatic longint unsigned ex2_q16(longint l, int ofrac, output bit sat);
        longint i, sh;
        longint unsigned g, mant;
        sat = 0;
        if (l >= 0) i = l / 65536;
        else        i = -((-l + 65535) / 65536);
        g = longint'(l - i * 65536);
        mant = 64'd65536 + g - ((g * (64'd65536 - g) * 64'd22500) >> 32);
        sh = i + ofrac - 16;
        if (sh >= 0) begin
            if (sh > 40) begin
                sat = 1;
                return 0;
            end
            return mant << sh;
        end
        if (-sh >= 63) return 0;
        return mant >> (-sh);
    endfunction

    function automatic longint lg2_one_plus(longint unsigned c, longint unsigned f, longint lt);
        longint ls;
        longint unsigned s;
        bit ovf;
        if (c == 0 || f == 0) return 0;
        ls = lg2_q16(c, 12) + 2 * (lg2_q16(f, 16) + lt);
        if (ls >= 32 * 65536) return ls;
        s = ex2_q16(ls, 16, ovf);
        return lg2_q16(s + 64'd65536, 16);
    endfunction

    function automatic density_t karman_density(logic [1:0] op, logic [23:0] f,
                                                logic [15:0] u, logic [15:0] len,
                                                logic [15:0] sg);
        density_t d;
        longint lt, ld, l;
        longint unsigned v;
        bit ovf;
        d = '0;
        if (u == 0) begin
            d.status = ST_ZSPD;
            return d;
        end
        if (gain_r == 0 || sg == 0 || len == 0) return d;
        lt = lg2_q16(len, 4) - lg2_q16(u, 8);
        ld = lg2_one_plus(shape_r, f, lt);
        l = lg2_q16(gain_r, 12) + 2 * lg2_q16(sg, 10) + lt;
        if (op == OP_ALONG) l = l - (5 * ld) / 6;
        else                l = l - (11 * ld) / 6 + lg2_one_plus(rise_r, f, lt);
        v = ex2_q16(l, 12, ovf);
        if (ovf || v > 64'hFFFF_FFFF) begin
            d.psd = 32'hFFFF_FFFF;
            d.status = ST_SAT;
        end else begin
            d.psd = v[31:0];
        end
        return d;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        n_fail++;
    endtask

    initial n_fail = 0;
    assign n_waiting = density_q.size();

    always @(posedge aclk) begin
        density_t want;
        if (!aresetn) begin
            gain_r  <= GAIN_RST;
            shape_r <= SHAPE_RST;
            rise_r  <= RISE_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GAIN:  gain_r  <= cfg_data;
                    REG_SHAPE: shape_r <= cfg_data;
                    REG_RISE:  rise_r  <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                density_q.push_back(karman_density(s_opcode, s_frequency, s_mean_speed,
                                                   s_length_scale, s_sigma));
            if (m_valid && m_ready) begin
                if (density_q.size() == 0) begin
                    report_mismatch("unexpected beat psd", m_psd, 32'd0);
                end else begin
                    want = density_q.pop_front();
                    if (m_psd !== want.psd) report_mismatch("psd", m_psd, want.psd);
                    if (m_status !== want.status)
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                end
            end
        end
    end

endmodule

@@ tb/tb_karman_wind_spectrum_eval.sv @@
// testbench top for the wind spectrum evaluator: stimulus, handshakes and verdict
`timescale 1ns / 1ps
module tb_karman_wind_spectrum_eval;
    import kws_pkg::*;

    // cycles with no beat on any channel before the run is abandoned
    localparam int STALL_LIMIT = 5000;
    // pipeline depth plus some margin, used as the drain wait
    localparam int DRAIN_CYCLES = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = '0;
    logic [23:0] s_frequency = '0;
    logic [15:0] s_mean_speed = '0;
    logic [15:0] s_length_scale = '0;
    logic [15:0] s_sigma = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_psd;
    logic [1:0]  m_status;

    int n_fail, n_waiting;
    int send_idle_pct = 0;   // chance per cycle that the sender holds off
    int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
    int quiet_cycles = 0;

    always #5 aclk = ~aclk;

    karman_wind_spectrum_eval u_top (.*);

    kws_spectrum_checker u_chk (.*);

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog: any accepted beat on any channel resets the count
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_karman_wind_spectrum_eval NOT OK");
            $finish;
        end
    end

    // one register write, only called with nothing in flight
    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, wait for every expected beat, then for the pipeline to go quiet
    task automatic drain;
        s_valid <= 1'b0;
        while (n_waiting != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // present one input beat and hold it until accepted; valid stays up
    // into the next beat unless the sender decides to idle
    task automatic send_beat(logic [1:0] op, logic [23:0] f, logic [15:0] u,
                             logic [15:0] len, logic [15:0] sg);
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_frequency    <= f;
        s_mean_speed   <= u;
        s_length_scale <= len;
        s_sigma        <= sg;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
    endtask

    // random value of random bit length, so small and large magnitudes both occur
    function automatic logic [31:0] spread(int w);
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(3) == 0) return r & ((32'd1 << w) - 1);
        return r >> (32 - $urandom_range(1, w));
    endfunction

    task automatic random_beats(int count);
        logic [15:0] u;
        for (int k = 0; k < count; k++) begin
            u = 16'(spread(16));
            // zero mean speed now and then, otherwise keep the main path busy
            if ($urandom_range(19) == 0) u = 16'd0;
            else if (u == 0) u = 16'd1;
            send_beat(2'($urandom_range(3)), 24'(spread(24)), u, 16'(spread(16)),
                      16'(spread(16)));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default registers, field extremes and the special cases
        send_beat(OP_ALONG, 24'd0, 16'd256, 16'd16, 16'd1024);       // zero frequency
        send_beat(OP_ACROSS, 24'd0, 16'd256, 16'd16, 16'd1024);
        send_beat(OP_VERT, 24'd65536, 16'd2560, 16'd1600, 16'd2048);
        send_beat(OP_SPARE, 24'd65536, 16'd2560, 16'd1600, 16'd2048);  // opcode three
        send_beat(OP_ALONG, 24'd100, 16'd0, 16'd1600, 16'd2048);     // zero mean speed
        send_beat(OP_ACROSS, 24'hFFFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
        send_beat(OP_ALONG, 24'd100, 16'd256, 16'd0, 16'd2048);      // zero length scale
        send_beat(OP_VERT, 24'd100, 16'd256, 16'd1600, 16'd0);       // zero sigma
        send_beat(OP_ALONG, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(OP_ACROSS, 24'hFFFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
        send_beat(OP_ALONG, 24'd0, 16'd1, 16'hFFFF, 16'hFFFF);       // saturating
        send_beat(OP_VERT, 24'd1, 16'hFFFF, 16'd1, 16'd1);
        send_beat(OP_SPARE, 24'hFFFFFF, 16'hFFFF, 16'd1, 16'd1);
        send_beat(OP_ALONG, 24'd1, 16'd1, 16'd1, 16'd1);
        send_beat(OP_ACROSS, 24'h800000, 16'h8000, 16'h8000, 16'h8000);
        drain();

        // register sweeps, each with a mix of idling; the last repeats the first mix
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_GAIN, 24'hFFFFFF);
                    write_reg(REG_SHAPE, 24'hFFFFFF);
                    write_reg(REG_RISE, 24'hFFFFFF);
                end
                1: begin
                    write_reg(REG_GAIN, 24'd0);
                    write_reg(REG_SHAPE, 24'd0);
                    write_reg(REG_RISE, 24'd0);
                end
                2: begin
                    write_reg(REG_GAIN, 24'd1);
                    write_reg(REG_SHAPE, 24'd1);
                    write_reg(REG_RISE, 24'hFFFFFF);
                    write_reg(REG_SPARE, 24'h123456);  // beyond rise, no effect
                end
                3: begin
                    write_reg(REG_GAIN, GAIN_RST);
                    write_reg(REG_SHAPE, SHAPE_RST);
                    write_reg(REG_RISE, RISE_RST);
                end
                default: begin
                    write_reg(REG_GAIN, 24'($urandom_range(24'hFFFFFF)));
                    write_reg(REG_SHAPE, 24'($urandom_range(24'hFFFFFF)));
                    write_reg(REG_RISE, 24'(spread(24)));
                end
            endcase
            // idling mix: none, sender, receiver, both
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            random_beats(100);
            // sender holds off until the pipeline has emptied
            if (ph == 2) begin
                s_valid <= 1'b0;
                while (n_waiting != 0) @(posedge aclk);
            end
            random_beats(107);
            s_valid <= 1'b0;
            send_idle_pct = 0;
            recv_stall_pct = 0;
            drain();
        end

        if (n_fail == 0)
            $display("tb_karman_wind_spectrum_eval OK");
        else
            $display("tb_karman_wind_spectrum_eval NOT OK");
        $finish;
    end

endmodule
